// File: rtl/isotp_pkg.sv
package isotp_pkg;

  localparam int ID_W        = 12;
  localparam int BYTE_W      = 8;
  localparam int NUM_PAY     = 7;
  localparam int FF_BYTES    = 6;
  localparam int CF_BYTES    = 7;
  localparam int SF_MAX      = 7;
  localparam int CNT_W       = 3;
  localparam int REM_W       = 9;
  localparam int SEQ_W       = 4;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 5;

  localparam logic [7:0] FC_CODE = 8'h30;

  localparam logic [3:0] FT_SF = 4'h0;
  localparam logic [3:0] FT_FF = 4'h1;
  localparam logic [3:0] FT_CF = 4'h2;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_TYPE,
    ST_BAD_SF_LEN,
    ST_FC_EXPECTED,
    ST_CF_EXPECTED,
    ST_SEQ_MISMATCH,
    ST_EARLY_END,
    ST_HALTED
  } status_t;

  // One job = one group of results caused by a single request
  typedef struct packed {
    logic [ID_W-1:0]                  id;
    logic [NUM_PAY-1:0][BYTE_W-1:0]   bytes;
    logic [CNT_W-1:0]                 count;
    logic                             valid;
    logic                             msg_end;
    status_t                          status;
  } job_t;

endpackage

// File: rtl/isotp_front.sv
module isotp_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [isotp_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                               in_tuser,
  input  logic                               fifo_full,
  output logic                               push,
  output isotp_pkg::job_t                    job
);
  import isotp_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_WAIT_FC, PH_WAIT_CF, PH_HALT} phase_t;

  localparam logic signed [REM_W-1:0] CF_REM = REM_W'(CF_BYTES);

  phase_t                      phase_r, phase_nxt;
  logic signed [REM_W-1:0]     rem_r, rem_nxt;
  logic [SEQ_W-1:0]            seq_r, seq_nxt;
  logic [ID_W-1:0]             cid_r, cid_nxt;

  logic [ID_W-1:0]             fid;
  logic [7:0]                  pci;
  logic [3:0]                  ftype;
  logic [3:0]                  low;
  logic [NUM_PAY-1:0][BYTE_W-1:0] pay;
  logic                        accept;
  logic                        err;
  status_t                     err_code;

  assign in_tready = !fifo_full;
  assign accept    = in_tvalid && in_tready;
  assign fid       = in_tdata[ID_W-1:0];
  assign pci       = in_tdata[ID_W +: 8];
  assign ftype     = pci[7:4];
  assign low       = pci[3:0];

  always_comb begin
    for (int i = 0; i < NUM_PAY; i++) begin
      pay[i] = in_tdata[ID_W + 8 + BYTE_W*i +: BYTE_W];
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    rem_nxt     = rem_r;
    seq_nxt     = seq_r;
    cid_nxt     = cid_r;
    push        = 1'b0;
    err         = 1'b0;
    err_code    = ST_OK;
    job         = '0;
    job.count   = CNT_W'(1);
    job.status  = ST_OK;

    if (accept) begin
      if (phase_r == PH_HALT) begin
        err      = 1'b1;
        err_code = ST_HALTED;
      end else if (in_tuser) begin
        if (phase_r != PH_IDLE) begin
          err      = 1'b1;
          err_code = ST_EARLY_END;
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            unique case (ftype)
              FT_SF: begin
                if (low > 4'(SF_MAX)) begin
                  err      = 1'b1;
                  err_code = ST_BAD_SF_LEN;
                end else if (low == 4'd0) begin
                  push        = 1'b1;
                  job.id      = fid;
                  job.msg_end = 1'b1;
                end else begin
                  push        = 1'b1;
                  job.id      = fid;
                  job.bytes   = pay;
                  job.count   = low[CNT_W-1:0];
                  job.valid   = 1'b1;
                  job.msg_end = 1'b1;
                end
              end
              FT_FF: begin
                cid_nxt   = fid;
                rem_nxt   = $signed({1'b0, pay[0]}) - $signed(REM_W'(FF_BYTES));
                phase_nxt = PH_WAIT_FC;
                push      = 1'b1;
                job.id    = fid;
                for (int i = 0; i < FF_BYTES; i++) begin
                  job.bytes[i] = pay[i+1];
                end
                job.count = CNT_W'(FF_BYTES);
                job.valid = 1'b1;
              end
              default: begin
                err      = 1'b1;
                err_code = ST_BAD_TYPE;
              end
            endcase
          end
          PH_WAIT_FC: begin
            if (pci != FC_CODE) begin
              err      = 1'b1;
              err_code = ST_FC_EXPECTED;
            end else if (rem_r <= 0) begin
              // short first frame: flow control closes the message
              phase_nxt   = PH_IDLE;
              push        = 1'b1;
              job.id      = cid_r;
              job.msg_end = 1'b1;
            end else begin
              seq_nxt   = SEQ_W'(1);
              phase_nxt = PH_WAIT_CF;
            end
          end
          PH_WAIT_CF: begin
            if (ftype != FT_CF) begin
              err      = 1'b1;
              err_code = ST_CF_EXPECTED;
            end else if (low != seq_r) begin
              err      = 1'b1;
              err_code = ST_SEQ_MISMATCH;
            end else begin
              push      = 1'b1;
              job.id    = cid_r;
              job.bytes = pay;
              job.count = (rem_r < CF_REM) ? rem_r[CNT_W-1:0] : CNT_W'(CF_BYTES);
              job.valid = 1'b1;
              rem_nxt   = rem_r - CF_REM;
              seq_nxt   = seq_r + SEQ_W'(1);
              if (rem_r <= CF_REM) begin
                job.msg_end = 1'b1;
                phase_nxt   = PH_IDLE;
              end
            end
          end
          default: ;
        endcase
      end

      if (err) begin
        push       = 1'b1;
        job        = '0;
        job.count  = CNT_W'(1);
        job.status = err_code;
        phase_nxt  = PH_HALT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      rem_r   <= '0;
      seq_r   <= SEQ_W'(1);
      cid_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      seq_r   <= seq_nxt;
      cid_r   <= cid_nxt;
    end
  end

endmodule

// File: rtl/isotp_fifo.sv
module isotp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  isotp_pkg::job_t   wr_job,
  output logic              full,
  input  logic              pop,
  output isotp_pkg::job_t   rd_job,
  output logic              empty
);
  import isotp_pkg::*;

  job_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;

  assign full   = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/isotp_back.sv
module isotp_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               empty,
  input  isotp_pkg::job_t                    rd_job,
  output logic                               pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [isotp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [isotp_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                               out_tlast
);
  import isotp_pkg::*;

  logic [CNT_W-1:0]        k_r, k_nxt;
  logic                    valid_r, valid_nxt;
  logic [ID_W-1:0]         id_r;
  logic [BYTE_W-1:0]       byte_r;
  logic                    bvalid_r, mend_r, last_r;
  status_t                 status_r;

  logic                    load;
  logic                    is_last;

  assign load    = !empty && (!valid_r || out_tready);
  assign is_last = (k_r + CNT_W'(1)) == rd_job.count;
  assign pop     = load && is_last;

  always_comb begin
    k_nxt     = k_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      k_nxt     = is_last ? '0 : k_r + CNT_W'(1);
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      k_r     <= '0;
    end else begin
      valid_r <= valid_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      id_r     <= rd_job.id;
      byte_r   <= rd_job.bytes[k_r];
      bvalid_r <= rd_job.valid;
      mend_r   <= rd_job.msg_end && is_last;
      last_r   <= is_last;
      status_r <= rd_job.status;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-ID_W-BYTE_W){1'b0}}, byte_r, id_r};
  assign out_tuser  = {status_r, mend_r, bvalid_r};
  assign out_tlast  = last_r;

endmodule

// File: rtl/isotp_frame_reassembler.sv
// Channel | Direction | Handshake          | Contents
// in_     | input     | tvalid/tready      | tdata: frame/PCI/payload, tuser: end marker
// out_    | output    | tvalid/tready      | tdata: id/byte, tuser: flags/status, tlast
//
// A frame is decoded in the cycle it is taken; results leave one per cycle
// while out_tready is high, and a frame yields 0 to 7 results.
// A 4-entry job queue separates the decoder from the output stage.
// Synchronous active-low reset clears the phase, counters and the queue.
// in_tready drops only while the queue is full; out_tready stalls the output.
module isotp_frame_reassembler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // frame_id, pci_byte, payload_1 .. payload_7, 4 zero bits
  input  logic [isotp_pkg::IN_TDATA_W-1:0]   in_tdata,
  // end_of_input
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // message_id, data_byte, 4 zero bits
  output logic [isotp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // byte_valid, message_end, status
  output logic [isotp_pkg::OUT_TUSER_W-1:0]  out_tuser,
  // item_last
  output logic                               out_tlast
);
  import isotp_pkg::*;

  logic   push, pop, full, empty;
  job_t   wr_job, rd_job;

  isotp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fifo_full (full),
    .push      (push),
    .job       (wr_job)
  );

  isotp_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .full   (full),
    .pop    (pop),
    .rd_job (rd_job),
    .empty  (empty)
  );

  isotp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .rd_job     (rd_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
